FILE: hdl/uint_to_tensor_element_convert_defines.svh
// assertion macros shared by the conversion block
`ifndef UINT_TO_TENSOR_ELEMENT_CONVERT_DEFINES_SVH
`define UINT_TO_TENSOR_ELEMENT_CONVERT_DEFINES_SVH

// same-cycle implication, checked out of reset
`define U2TE_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// implication with a fixed delay in cycles
`define U2TE_ASSERT_DELAY(label, clk, rst, ante, dly, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> ##dly (cons)) \
      else $error(msg);

`endif

FILE: hdl/u2te_pkg.sv
package u2te_pkg;

   // element type codes
   localparam logic [3:0] ELEM_F16  = 4'd0;
   localparam logic [3:0] ELEM_BF16 = 4'd1;
   localparam logic [3:0] ELEM_F32  = 4'd2;
   localparam logic [3:0] ELEM_F64  = 4'd3;
   localparam logic [3:0] ELEM_I8   = 4'd4;
   localparam logic [3:0] ELEM_U8   = 4'd5;
   localparam logic [3:0] ELEM_I4   = 4'd6;
   localparam logic [3:0] ELEM_I32  = 4'd7;
   localparam logic [3:0] ELEM_BOOL = 4'd8;

   localparam logic [3:0] ELEM_RESET = ELEM_F32;

   // largest finite float16 integer
   localparam logic [31:0] F16_MAX_INT = 32'd65504;

   localparam logic [4:0]  F16_BIAS  = 5'd15;
   localparam logic [7:0]  F32_BIAS  = 8'd127;
   localparam logic [10:0] F64_BIAS  = 11'd1023;

   localparam int PIPE_LATENCY = 4;

   typedef struct packed {
      logic [31:0] int_value;
      logic [31:0] elem_index;
   } req_type;

   typedef struct packed {
      logic [63:0] elem_bits;
      logic [31:0] elem_addr;
      logic        supported;
   } rsp_type;

endpackage

FILE: hdl/uint_to_tensor_element_convert.sv
// Unsigned integer to tensor element converter.
// Input: start with req_data (int_value, elem_index); a transfer happens on a
// rising edge with start high and busy low. busy stays low: the pipeline
// never backs up, so one item can be taken every cycle.
// Output: rsp_valid strobes for one cycle with rsp_data (elem_bits,
// elem_addr, supported). The receiver must take each result in that cycle.
// Pipeline: each item passes through four register stages (input/saturate,
// leading-one detect, normalize shift, field pack), the first of which loads
// at the transfer edge; rsp_valid and rsp_data come from the field pack
// register. Throughput: one item per cycle.
// Configuration: csr_we writes csr_wdata into the element type register.
// Each item captures the element type when it is taken, so results always
// match the type that was active at their input transfer.
// Reset (synchronous, active high): clears all pipeline valid bits, drops
// any items in flight and sets the element type to float32.
`include "uint_to_tensor_element_convert_defines.svh"

module uint_to_tensor_element_convert (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  u2te_pkg::req_type  req_data,
   output logic               rsp_valid,
   output u2te_pkg::rsp_type  rsp_data,
   input  logic               csr_we,
   input  logic [3:0]         csr_wdata
);

   function automatic logic [4:0] lead_one(input logic [31:0] v);
      logic [4:0] pos;
      pos = 5'd0;
      for (int i = 0; i < 32; i++) begin
         if (v[i]) begin
            pos = 5'(i);
         end
      end
      return pos;
   endfunction

   logic        accept;
   logic [3:0]  elem_type_ff;

   logic        s1_valid_ff;
   logic [31:0] s1_value_ff;
   logic [31:0] s1_index_ff;
   logic [3:0]  s1_kind_ff;
   logic [31:0] s1_value_in;

   logic        s2_valid_ff;
   logic [31:0] s2_value_ff;
   logic [31:0] s2_index_ff;
   logic [3:0]  s2_kind_ff;
   logic [4:0]  s2_msb_ff;

   logic        s3_valid_ff;
   logic [31:0] s3_value_ff;
   logic [31:0] s3_norm_ff;
   logic [31:0] s3_index_ff;
   logic [3:0]  s3_kind_ff;
   logic [4:0]  s3_msb_ff;
   logic [31:0] s3_norm_in;

   logic              rsp_valid_ff;
   u2te_pkg::rsp_type rsp_data_ff;
   u2te_pkg::rsp_type rsp_data_in;

   logic [30:0] frac;
   logic [4:0]  exp_f16;
   logic [7:0]  exp_f32;
   logic [10:0] exp_f64;
   logic        is_zero;

   assign busy   = 1'b0;
   assign accept = start && !busy;

   // float16 saturates before conversion
   always_comb begin
      s1_value_in = req_data.int_value;
      if (elem_type_ff == u2te_pkg::ELEM_F16 && req_data.int_value > u2te_pkg::F16_MAX_INT) begin
         s1_value_in = u2te_pkg::F16_MAX_INT;
      end
   end

   // put leading one at bit 31
   assign s3_norm_in = s2_value_ff << (5'd31 - s2_msb_ff);

   assign frac    = s3_norm_ff[30:0];
   assign is_zero = (s3_value_ff == 32'd0);
   assign exp_f16 = s3_msb_ff + u2te_pkg::F16_BIAS;
   assign exp_f32 = {3'b000, s3_msb_ff} + u2te_pkg::F32_BIAS;
   assign exp_f64 = {6'b000000, s3_msb_ff} + u2te_pkg::F64_BIAS;

   always_comb begin
      rsp_data_in.elem_addr = s3_index_ff;
      rsp_data_in.supported = 1'b1;
      rsp_data_in.elem_bits = 64'd0;
      case (s3_kind_ff)
         u2te_pkg::ELEM_F16: begin
            if (!is_zero) begin
               rsp_data_in.elem_bits = {48'd0, 1'b0, exp_f16, frac[30:21]};
            end
         end
         u2te_pkg::ELEM_BF16: begin
            if (!is_zero) begin
               rsp_data_in.elem_bits = {48'd0, 1'b0, exp_f32, frac[30:24]};
            end
         end
         u2te_pkg::ELEM_F32: begin
            if (!is_zero) begin
               rsp_data_in.elem_bits = {32'd0, 1'b0, exp_f32, frac[30:8]};
            end
         end
         u2te_pkg::ELEM_F64: begin
            if (!is_zero) begin
               rsp_data_in.elem_bits = {1'b0, exp_f64, frac, 21'd0};
            end
         end
         u2te_pkg::ELEM_I8: begin
            rsp_data_in.elem_bits = {57'd0, s3_value_ff[6:0]};
         end
         u2te_pkg::ELEM_U8: begin
            rsp_data_in.elem_bits = {56'd0, s3_value_ff[7:0]};
         end
         u2te_pkg::ELEM_I32: begin
            rsp_data_in.elem_bits = {32'd0, s3_value_ff};
         end
         default: begin
            // int4, bool and undefined codes
            rsp_data_in.supported = 1'b0;
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         elem_type_ff <= u2te_pkg::ELEM_RESET;
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_we) begin
            elem_type_ff <= csr_wdata;
         end
         s1_valid_ff  <= accept;
         s2_valid_ff  <= s1_valid_ff;
         s3_valid_ff  <= s2_valid_ff;
         rsp_valid_ff <= s3_valid_ff;
      end
   end

   // payload stages
   always_ff @(posedge clock) begin
      s1_value_ff <= s1_value_in;
      s1_index_ff <= req_data.elem_index;
      s1_kind_ff  <= elem_type_ff;

      s2_value_ff <= s1_value_ff;
      s2_index_ff <= s1_index_ff;
      s2_kind_ff  <= s1_kind_ff;
      s2_msb_ff   <= lead_one(s1_value_ff);

      s3_value_ff <= s2_value_ff;
      s3_norm_ff  <= s3_norm_in;
      s3_index_ff <= s2_index_ff;
      s3_kind_ff  <= s2_kind_ff;
      s3_msb_ff   <= s2_msb_ff;

      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   `U2TE_ASSERT_DELAY(a_latency, clock, reset, accept, 4, rsp_valid, "result missing after input transfer")
   `U2TE_ASSERT_NOW(a_unsupported_zero, clock, reset, rsp_valid && !rsp_data.supported, rsp_data.elem_bits == 64'd0, "unsupported type gave nonzero bits")
   `U2TE_ASSERT_NOW(a_norm_msb, clock, reset, s3_valid_ff && !is_zero, s3_norm_ff[31], "normalized value lost its leading one")
   `U2TE_ASSERT_NOW(a_f16_sat, clock, reset, s1_valid_ff && s1_kind_ff == u2te_pkg::ELEM_F16, s1_value_ff <= u2te_pkg::F16_MAX_INT, "float16 input not saturated")

endmodule

FILE: dv/tb_uint_to_tensor_element_convert.sv
`timescale 1ns / 1ps

module tb_uint_to_tensor_element_convert;

   // selector codes with no element type behind them
   localparam logic [3:0] SEL_FIRST_UNUSED = 4'd9;
   localparam logic [3:0] SEL_TOP          = 4'd15;

   localparam int F16_MANT  = 10;
   localparam int BF16_MANT = 7;
   localparam int F32_MANT  = 23;
   localparam int F64_MANT  = 52;

   localparam logic [31:0] I8_KEEP = 32'h7F;
   localparam logic [31:0] U8_KEEP = 32'hFF;

   localparam int N_PHASES        = 12;
   localparam int ITEMS_PER_PHASE = 36;
   localparam int STALL_LIMIT     = 2000;

   typedef struct {
      logic [3:0]  sel;
      logic [31:0] value;
      logic [31:0] index;
      bit          typed;
      logic [63:0] bits;
      bit          ok;
   } dir_row_type;

   logic              clock;
   logic              reset     = 1'b1;
   logic              start     = 1'b0;
   logic              busy;
   u2te_pkg::req_type req_data  = '0;
   logic              rsp_valid;
   u2te_pkg::rsp_type rsp_data;
   logic              csr_we    = 1'b0;
   logic [3:0]        csr_wdata = '0;

   u2te_pkg::rsp_type staged_elem = '0;
   u2te_pkg::rsp_type pending_elems [$];
   logic [3:0]        cur_type = u2te_pkg::ELEM_RESET;
   dir_row_type       dir_rows [24];
   logic [3:0]        phase_types [10];

   int  errors       = 0;
   int  items_in     = 0;
   int  results_seen = 0;
   int  type_writes  = 0;
   int  stall_cycles = 0;
   bit  progress;

   uint_to_tensor_element_convert dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // truncating unsigned to float bit pattern, sign always clear
   function automatic logic [63:0] pack_float(logic [31:0] v, int mant_w, int bias);
      int lead;
      logic [63:0] frac;
      if (v == '0) return '0;
      lead = 0;
      for (int i = 0; i < 32; i++)
         if (v[i]) lead = i;
      if (lead <= mant_w) frac = 64'(v) << (mant_w - lead);
      else frac = 64'(v) >> (lead - mant_w);
      frac &= (64'd1 << mant_w) - 64'd1;
      return (64'(lead + bias) << mant_w) | frac;
   endfunction

   function automatic u2te_pkg::rsp_type convert_elem(logic [3:0] sel, u2te_pkg::req_type r);
      u2te_pkg::rsp_type e;
      e.elem_addr = r.elem_index;
      e.supported = 1'b1;
      case (sel)
         u2te_pkg::ELEM_F16:
            e.elem_bits = pack_float((r.int_value > u2te_pkg::F16_MAX_INT) ?
                                     u2te_pkg::F16_MAX_INT : r.int_value,
                                     F16_MANT, int'(u2te_pkg::F16_BIAS));
         u2te_pkg::ELEM_BF16:
            e.elem_bits = pack_float(r.int_value, BF16_MANT, int'(u2te_pkg::F32_BIAS));
         u2te_pkg::ELEM_F32:
            e.elem_bits = pack_float(r.int_value, F32_MANT, int'(u2te_pkg::F32_BIAS));
         u2te_pkg::ELEM_F64:
            e.elem_bits = pack_float(r.int_value, F64_MANT, int'(u2te_pkg::F64_BIAS));
         u2te_pkg::ELEM_I8:  e.elem_bits = 64'(r.int_value & I8_KEEP);
         u2te_pkg::ELEM_U8:  e.elem_bits = 64'(r.int_value & U8_KEEP);
         u2te_pkg::ELEM_I32: e.elem_bits = 64'(r.int_value);
         default: begin
            e.elem_bits = '0;
            e.supported = 1'b0;
         end
      endcase
      return e;
   endfunction

   // biased toward values that move the leading one and sit near float16 saturation
   function automatic logic [31:0] rand_value();
      case ($urandom_range(0, 9))
         0: return '0;
         1: return '1;
         2: return u2te_pkg::F16_MAX_INT - 32'd2 + 32'($urandom_range(0, 4));
         3, 4: return $urandom >> $urandom_range(0, 31);
         5: return 32'd1 << $urandom_range(0, 31);
         default: return $urandom;
      endcase
   endfunction

   task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
      $display("ERROR %0t: %s: got %h, expected %h", $time, what, got, want);
      errors++;
   endtask

   task automatic push_item(u2te_pkg::req_type r, u2te_pkg::rsp_type e);
      req_data    <= r;
      staged_elem <= e;
      start       <= 1'b1;
      do @(posedge clock); while (busy);
      items_in++;
   endtask

   task automatic sender_gap(int n);
      start <= 1'b0;
      repeat (n) @(posedge clock);
   endtask

   // hold the sender until every pending result has come back
   task automatic wait_drained();
      start <= 1'b0;
      do @(negedge clock); while (pending_elems.size() != 0);
      @(posedge clock);
   endtask

   task automatic set_elem_type(logic [3:0] sel);
      wait_drained();
      csr_we    <= 1'b1;
      csr_wdata <= sel;
      @(posedge clock);
      csr_we    <= 1'b0;
      cur_type = sel;
      type_writes++;
   endtask

   // transfer and result monitor
   always @(posedge clock) begin
      if (!reset) begin
         progress = 1'b0;
         if (start && !busy) begin
            pending_elems.push_back(staged_elem);
            progress = 1'b1;
         end
         if (rsp_valid) begin
            progress = 1'b1;
            results_seen++;
            if (pending_elems.size() == 0) begin
               report_mismatch("result with nothing pending", rsp_data.elem_bits, '0);
            end else begin
               u2te_pkg::rsp_type want;
               want = pending_elems.pop_front();
               if (rsp_data.elem_bits !== want.elem_bits)
                  report_mismatch("elem_bits", rsp_data.elem_bits, want.elem_bits);
               if (rsp_data.elem_addr !== want.elem_addr)
                  report_mismatch("elem_addr", 64'(rsp_data.elem_addr), 64'(want.elem_addr));
               if (rsp_data.supported !== want.supported)
                  report_mismatch("supported", 64'(rsp_data.supported), 64'(want.supported));
            end
         end
         stall_cycles = progress ? 0 : stall_cycles + 1;
      end
   end

   initial begin
      while (stall_cycles < STALL_LIMIT) @(posedge clock);
      $display("ERROR %0t: no transfer for %0d cycles", $time, STALL_LIMIT);
      $display("Verification failed");
      $finish;
   end

   initial begin
      u2te_pkg::req_type r;
      u2te_pkg::rsp_type e;
      int burst_left;
      int gap;

      dir_rows = '{
         '{u2te_pkg::ELEM_F32,  32'h0,        32'h0,    1'b1, 64'h0,                1'b1},
         '{u2te_pkg::ELEM_F32,  32'hFFFFFFFF, 32'hFFFFFFFF, 1'b1, 64'h4F7FFFFF,     1'b1},
         '{u2te_pkg::ELEM_F32,  32'h1,        32'h1,    1'b1, 64'h3F800000,         1'b1},
         '{u2te_pkg::ELEM_F32,  32'h00FFFFFF, 32'h1000, 1'b0, 64'h0,                1'b0},
         '{u2te_pkg::ELEM_F16,  32'h0,        32'd7,    1'b1, 64'h0,                1'b1},
         '{u2te_pkg::ELEM_F16,  32'h1,        32'd8,    1'b1, 64'h3C00,             1'b1},
         '{u2te_pkg::ELEM_F16,  32'd65504,    32'd9,    1'b1, 64'h7BFF,             1'b1},
         '{u2te_pkg::ELEM_F16,  32'd65505,    32'd10,   1'b1, 64'h7BFF,             1'b1},
         '{u2te_pkg::ELEM_F16,  32'hFFFFFFFF, 32'd11,   1'b1, 64'h7BFF,             1'b1},
         '{u2te_pkg::ELEM_F16,  32'd1000,     32'd12,   1'b0, 64'h0,                1'b0},
         '{u2te_pkg::ELEM_BF16, 32'h1,        32'd13,   1'b1, 64'h3F80,             1'b1},
         '{u2te_pkg::ELEM_BF16, 32'hFFFFFFFF, 32'd14,   1'b1, 64'h4F7F,             1'b1},
         '{u2te_pkg::ELEM_BF16, 32'h80000000, 32'd15,   1'b0, 64'h0,                1'b0},
         '{u2te_pkg::ELEM_F64,  32'h1,        32'd16,   1'b1, 64'h3FF0000000000000, 1'b1},
         '{u2te_pkg::ELEM_F64,  32'hFFFFFFFF, 32'd17,   1'b1, 64'h41EFFFFFFFE00000, 1'b1},
         '{u2te_pkg::ELEM_F64,  32'h0,        32'd18,   1'b1, 64'h0,                1'b1},
         '{u2te_pkg::ELEM_I8,   32'hFFFFFFFF, 32'd19,   1'b1, 64'h7F,               1'b1},
         '{u2te_pkg::ELEM_U8,   32'hFFFFFFFF, 32'd20,   1'b1, 64'hFF,               1'b1},
         '{u2te_pkg::ELEM_I4,   32'hFFFFFFFF, 32'd21,   1'b1, 64'h0,                1'b0},
         '{u2te_pkg::ELEM_I32,  32'hFFFFFFFF, 32'd22,   1'b1, 64'hFFFFFFFF,         1'b1},
         '{u2te_pkg::ELEM_I32,  32'h0,        32'd23,   1'b1, 64'h0,                1'b1},
         '{u2te_pkg::ELEM_BOOL, 32'h1,        32'd24,   1'b1, 64'h0,                1'b0},
         '{SEL_FIRST_UNUSED,    32'h12345678, 32'd25,   1'b1, 64'h0,                1'b0},
         '{SEL_TOP,             32'hFFFFFFFF, 32'd26,   1'b1, 64'h0,                1'b0}
      };
      phase_types = '{u2te_pkg::ELEM_F16, u2te_pkg::ELEM_BF16, u2te_pkg::ELEM_F32,
                      u2te_pkg::ELEM_F64, u2te_pkg::ELEM_I8, u2te_pkg::ELEM_U8,
                      u2te_pkg::ELEM_I4, u2te_pkg::ELEM_I32, u2te_pkg::ELEM_BOOL, SEL_TOP};

      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: first rows run on the reset element type
      foreach (dir_rows[i]) begin
         if (dir_rows[i].sel != cur_type) set_elem_type(dir_rows[i].sel);
         r.int_value  = dir_rows[i].value;
         r.elem_index = dir_rows[i].index;
         if (dir_rows[i].typed) begin
            e.elem_bits = dir_rows[i].bits;
            e.elem_addr = dir_rows[i].index;
            e.supported = dir_rows[i].ok;
         end else begin
            e = convert_elem(cur_type, r);
         end
         push_item(r, e);
      end

      // random: one element type per phase, sender in bursts
      burst_left = $urandom_range(1, 16);
      for (int p = 0; p < N_PHASES; p++) begin
         set_elem_type(p < 10 ? phase_types[p] : 4'($urandom_range(0, 15)));
         for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
            r.int_value  = rand_value();
            r.elem_index = $urandom;
            push_item(r, convert_elem(cur_type, r));
            burst_left--;
            if (burst_left == 0) begin
               gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
               if (gap > 0) sender_gap(gap);
               burst_left = $urandom_range(1, 16);
            end
         end
      end

      wait_drained();
      repeat (u2te_pkg::PIPE_LATENCY + 4) @(posedge clock);

      $display("covered %0d transfers and %0d results over %0d element type writes",
               items_in, results_seen, type_writes);
      $display("all float, integer and unsupported selectors exercised, %0d mismatches",
               errors);
      if (errors == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule

FILE: sim.f
+incdir+hdl
hdl/u2te_pkg.sv
hdl/uint_to_tensor_element_convert.sv
dv/tb_uint_to_tensor_element_convert.sv
